FILE: rtl/dsc_pkg.sv
// Package for the disk schedule cost block: sizes, policy codes, field widths.
// Used by rtl/disk_schedule_cost.sv; depends on nothing.
package dsc_pkg;
    localparam int MAX_REQ  = 1024;
    localparam int ADDR_W   = $clog2(MAX_REQ);
    localparam int CNT_W    = $clog2(MAX_REQ + 1);
    localparam int CYL_W    = 16;
    localparam int TRAV_W   = 24;
    localparam int TURN_W   = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int POL_W    = 2;
    localparam logic [CYL_W-1:0] TOP_RESET = CYL_W'(4999);

    localparam logic [POL_W-1:0] POL_FCFS  = 2'd0;
    localparam logic [POL_W-1:0] POL_SSTF  = 2'd1;
    localparam logic [POL_W-1:0] POL_SCAN  = 2'd2;
    localparam logic [POL_W-1:0] POL_CSCAN = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PREV   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd3;

    function automatic logic [CYL_W-1:0] cyl_dist(input logic [CYL_W-1:0] a,
                                                  input logic [CYL_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction
endpackage

FILE: rtl/disk_schedule_cost.sv
// Disk schedule cost: head travel and direction changes for FCFS, SSTF, SCAN, C-SCAN.
// Loads one request per cycle while idle; after the last one FCFS, SCAN and C-SCAN
// make one read pass over the store, SSTF one pass per served request (one store
// read per entry per pass), all through its single read port. No request is taken
// during that work; a result waiting on m_tready holds only the finish of the next list, loading goes on.
// Reset (aresetn, synchronous): registers to their defaults, list empty, no result.
module disk_schedule_cost (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [dsc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [dsc_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] request_cylinder
    input  logic                                s_tlast,   // last_request
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [39:0]                         m_tdata    // [23:0] total_travel, [35:24] direction_changes
);
    import dsc_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_MARK  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;

    localparam logic [TRAV_W-1:0] TRAV_MAX = '1;
    localparam logic [TURN_W-1:0] TURN_MAX = '1;

    // configuration registers
    logic [POL_W-1:0] policy_reg;
    logic [CYL_W-1:0] start_reg, prev_reg, top_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= POL_FCFS;
            start_reg  <= '0;
            prev_reg   <= '0;
            top_reg    <= TOP_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_POLICY: policy_reg <= cfg_data[POL_W-1:0];
                REG_START:  start_reg  <= cfg_data[CYL_W-1:0];
                REG_PREV:   prev_reg   <= cfg_data[CYL_W-1:0];
                REG_TOP:    top_reg    <= cfg_data[CYL_W-1:0];
                default: ;
            endcase
        end
    end

    // request store: {served mark, cylinder}
    logic [CYL_W:0]      mem [MAX_REQ];
    logic                mem_we, mem_re;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [CYL_W:0]      mem_wdata, rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) rdata_reg <= mem[mem_raddr];
    end

    logic [2:0]         state_reg;
    logic [CNT_W-1:0]   count_reg, idx_reg, pass_reg;
    logic               pend_reg;
    logic [CYL_W-1:0]   head_reg;
    logic               up_reg;
    logic [TRAV_W-1:0]  travel_reg;
    logic [TURN_W-1:0]  turns_reg;
    logic               found_reg;
    logic [CYL_W-1:0]   bestd_reg, bestcyl_reg;
    logic [ADDR_W-1:0]  bestidx_reg;
    logic               nlow_reg, nup_reg;
    logic [CYL_W-1:0]   lmin_reg, lmax_reg, umin_reg, umax_reg;
    logic               m_valid_reg;
    logic [TRAV_W-1:0]  m_trav_reg;
    logic [TURN_W-1:0]  m_turn_reg;

    // load only while idle; the result register parts input from output
    logic s_xfer;
    assign s_tready = (state_reg == ST_LOAD);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, m_turn_reg, m_trav_reg};

    // store port control
    logic scan_issue;
    assign scan_issue = (state_reg == ST_SCAN) && (idx_reg < count_reg);
    assign mem_re     = scan_issue;
    assign mem_raddr  = idx_reg[ADDR_W-1:0];
    assign mem_we     = (s_xfer && !count_reg[CNT_W-1]) || (state_reg == ST_MARK);
    assign mem_waddr  = (state_reg == ST_MARK) ? bestidx_reg : count_reg[ADDR_W-1:0];
    assign mem_wdata  = (state_reg == ST_MARK) ? {1'b1, bestcyl_reg}
                                               : {1'b0, s_tdata[CYL_W-1:0]};

    // result hand-off: finish a list only when the result register is free
    logic out_free, sstf_last, fin;
    assign out_free  = !m_valid_reg || m_tready;
    assign sstf_last = (pass_reg + CNT_W'(1)) == count_reg;
    assign fin = out_free &&
                 (((state_reg == ST_SCAN) && !scan_issue && !pend_reg &&
                   (policy_reg == POL_FCFS)) ||
                  ((state_reg == ST_MARK) && sstf_last) ||
                  (state_reg == ST_SWEEP));

    // head move: shared by FCFS per item and SSTF per pass
    logic [CYL_W-1:0]  mv_tgt, mv_d;
    logic              mv_up;
    logic [TRAV_W:0]   mv_sum;
    logic [TRAV_W-1:0] mv_trav;
    logic [TURN_W-1:0] mv_turns;
    always_comb begin
        mv_tgt   = (state_reg == ST_MARK) ? bestcyl_reg : rdata_reg[CYL_W-1:0];
        mv_up    = mv_tgt >= head_reg;
        mv_d     = cyl_dist(mv_tgt, head_reg);
        mv_sum   = {1'b0, travel_reg} + (TRAV_W+1)'(mv_d);
        mv_trav  = mv_sum[TRAV_W] ? TRAV_MAX : mv_sum[TRAV_W-1:0];
        mv_turns = (mv_up != up_reg && turns_reg != TURN_MAX) ? turns_reg + 1'b1 : turns_reg;
    end

    // SSTF candidate distance
    logic [CYL_W-1:0] rd_d;
    assign rd_d = cyl_dist(rdata_reg[CYL_W-1:0], head_reg);

    // sweep end figures
    logic [TRAV_W-1:0] sw_trav;
    logic [TURN_W-1:0] sw_turns;
    logic              circ;
    always_comb begin
        logic [TRAV_W-1:0] s, t, lmn, lmx, umn, umx;
        s = TRAV_W'(start_reg); t = TRAV_W'(top_reg);
        lmn = TRAV_W'(lmin_reg); lmx = TRAV_W'(lmax_reg);
        umn = TRAV_W'(umin_reg); umx = TRAV_W'(umax_reg);
        circ = (policy_reg == POL_CSCAN);
        sw_trav = '0;
        sw_turns = '0;
        if (up_reg) begin
            if (nup_reg) sw_trav = umx - s;
            if (nlow_reg) begin
                if (!circ) begin
                    sw_turns = TURN_W'(1);
                    if (!nup_reg) sw_trav = s - lmn;
                    else sw_trav = sw_trav + (t - umx)
                                 + TRAV_W'(cyl_dist(lmax_reg, top_reg)) + (lmx - lmn);
                end else begin
                    sw_turns = TURN_W'(2);
                    if (!nup_reg) sw_trav = TRAV_W'(cyl_dist(top_reg, start_reg)) + t + lmx;
                    else sw_trav = sw_trav + (t - umx) + t + lmx;
                end
            end
        end else begin
            if (nlow_reg) sw_trav = s - lmn;
            if (nup_reg) begin
                if (!circ) begin
                    sw_turns = TURN_W'(1);
                    if (!nlow_reg) sw_trav = umx - s;
                    else sw_trav = sw_trav + lmn + umx;
                end else begin
                    sw_turns = TURN_W'(2);
                    sw_trav = sw_trav + (nlow_reg ? lmn : s) + t + (t - umn);
                end
            end
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            idx_reg     <= '0;
            pass_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            head_reg    <= '0;
            up_reg      <= 1'b1;
            travel_reg  <= '0;
            turns_reg   <= '0;
            found_reg   <= 1'b0;
            nlow_reg    <= 1'b0;
            nup_reg     <= 1'b0;
        end else begin
            if (fin) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_LOAD: begin
                    if (s_xfer) begin
                        if (!count_reg[CNT_W-1]) count_reg <= count_reg + 1'b1;
                        if (s_tlast) begin
                            head_reg   <= start_reg;
                            up_reg     <= start_reg >= prev_reg;
                            travel_reg <= '0;
                            turns_reg  <= '0;
                            idx_reg    <= '0;
                            pass_reg   <= '0;
                            pend_reg   <= 1'b0;
                            found_reg  <= 1'b0;
                            nlow_reg   <= 1'b0;
                            nup_reg    <= 1'b0;
                            lmin_reg   <= '1;
                            lmax_reg   <= '0;
                            umin_reg   <= '1;
                            umax_reg   <= '0;
                            state_reg  <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // issue next read, fold in the data of the previous one
                    pend_reg <= scan_issue;
                    if (scan_issue) idx_reg <= idx_reg + 1'b1;
                    if (pend_reg) begin
                        case (policy_reg)
                            POL_FCFS: begin
                                head_reg   <= mv_tgt;
                                up_reg     <= mv_up;
                                travel_reg <= mv_trav;
                                turns_reg  <= mv_turns;
                            end
                            POL_SSTF: begin
                                if (!rdata_reg[CYL_W] && (!found_reg || rd_d < bestd_reg)) begin
                                    found_reg   <= 1'b1;
                                    bestd_reg   <= rd_d;
                                    bestcyl_reg <= rdata_reg[CYL_W-1:0];
                                    bestidx_reg <= ADDR_W'(idx_reg - 1'b1);
                                end
                            end
                            default: begin
                                if (rdata_reg[CYL_W-1:0] <= start_reg) begin
                                    nlow_reg <= 1'b1;
                                    if (rdata_reg[CYL_W-1:0] < lmin_reg)
                                        lmin_reg <= rdata_reg[CYL_W-1:0];
                                    if (rdata_reg[CYL_W-1:0] > lmax_reg)
                                        lmax_reg <= rdata_reg[CYL_W-1:0];
                                end else if (rdata_reg[CYL_W-1:0] <= top_reg) begin
                                    nup_reg <= 1'b1;
                                    if (rdata_reg[CYL_W-1:0] < umin_reg)
                                        umin_reg <= rdata_reg[CYL_W-1:0];
                                    if (rdata_reg[CYL_W-1:0] > umax_reg)
                                        umax_reg <= rdata_reg[CYL_W-1:0];
                                end
                            end
                        endcase
                    end
                    if (!scan_issue && !pend_reg) begin
                        case (policy_reg)
                            POL_FCFS: begin
                                if (fin) begin
                                    m_trav_reg <= travel_reg;
                                    m_turn_reg <= turns_reg;
                                    count_reg  <= '0;
                                    state_reg  <= ST_LOAD;
                                end
                            end
                            POL_SSTF: state_reg <= ST_MARK;
                            default:  state_reg <= ST_SWEEP;
                        endcase
                    end
                end
                ST_MARK: begin
                    // serve the nearest request, then rescan or finish
                    if (!sstf_last || out_free) begin
                        head_reg   <= mv_tgt;
                        up_reg     <= mv_up;
                        travel_reg <= mv_trav;
                        turns_reg  <= mv_turns;
                        pass_reg   <= pass_reg + 1'b1;
                        idx_reg    <= '0;
                        found_reg  <= 1'b0;
                        if (sstf_last) begin
                            m_trav_reg <= mv_trav;
                            m_turn_reg <= mv_turns;
                            count_reg  <= '0;
                            state_reg  <= ST_LOAD;
                        end else begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (out_free) begin
                        m_trav_reg <= sw_trav;
                        m_turn_reg <= sw_turns;
                        count_reg  <= '0;
                        state_reg  <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    // checks
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_REQ))
        else $error("request count beyond store size");
    a_pend_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> $past(state_reg) == ST_SCAN)
        else $error("read pending without scan");
endmodule

FILE: dv/disk_schedule_cost_test.sv
`timescale 1ns / 100ps
// Testbench for disk_schedule_cost: request lists under all four policies, checked
// against a behavioral predictor of head travel and direction changes.
// Depends on rtl/dsc_pkg.sv and rtl/disk_schedule_cost.sv.
module disk_schedule_cost_test;
    import dsc_pkg::*;

    typedef struct packed {
        logic [15:0] cyl;
        logic        last;
        logic        hold;   // wait for the block to drain before this transfer
    } req_t;

    typedef struct {
        logic [23:0] travel;
        logic [11:0] turns;
    } cost_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    disk_schedule_cost dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state
    logic [1:0]  cur_policy;
    logic [15:0] cur_start, cur_prev, cur_top;
    logic [15:0] list_q[$];
    cost_t       cost_q[$];
    req_t        pending_q[$];
    int          n_bad = 0, n_checked = 0, n_lists = 0;
    bit          stim_done = 0;

    longint      acc_travel;
    int          acc_turns;
    longint      head;
    bit          going_up;

    function automatic longint span(longint a, longint b);
        return a >= b ? a - b : b - a;
    endfunction

    function automatic void bump_turns(int k);
        acc_turns += k;
        if (acc_turns > 4095) acc_turns = 4095;
    endfunction

    function automatic void seek(longint target);
        bit up;
        up = target >= head;
        if (up != going_up) begin
            bump_turns(1);
            going_up = up;
        end
        acc_travel += span(target, head);
        head = target;
    endfunction

    // compute the cost of the current list under the live register settings
    function automatic cost_t schedule_cost();
        cost_t  r;
        bit     done[];
        int     best, nlow, nup;
        longint bd, d, s, t, lmin, lmax, umin, umax, v;
        head = longint'(cur_start);
        going_up = cur_start >= cur_prev;
        acc_travel = 0;
        acc_turns = 0;
        s = longint'(cur_start);
        t = longint'(cur_top);
        case (cur_policy)
            POL_FCFS: foreach (list_q[i]) seek(longint'(list_q[i]));
            POL_SSTF: begin
                done = new[list_q.size()];
                for (int k = 0; k < list_q.size(); k++) begin
                    best = -1;
                    bd = 0;
                    foreach (list_q[i]) begin
                        if (done[i]) continue;
                        d = span(longint'(list_q[i]), head);
                        if (best < 0 || d < bd) begin
                            best = i;
                            bd = d;
                        end
                    end
                    done[best] = 1;
                    seek(longint'(list_q[best]));
                end
            end
            default: begin
                nlow = 0; nup = 0;
                lmin = 65535; lmax = 0; umin = 65535; umax = 0;
                foreach (list_q[i]) begin
                    v = longint'(list_q[i]);
                    if (v <= s) begin
                        nlow++;
                        if (v < lmin) lmin = v;
                        if (v > lmax) lmax = v;
                    end else if (v <= t) begin
                        nup++;
                        if (v < umin) umin = v;
                        if (v > umax) umax = v;
                    end
                end
                if (going_up) begin
                    if (nup != 0) acc_travel += umax - s;
                    if (nlow != 0) begin
                        if (cur_policy == POL_SCAN) begin
                            bump_turns(1);
                            if (nup == 0) acc_travel += s - lmin;
                            else acc_travel += (t - umax) + span(lmax, t) + (lmax - lmin);
                        end else begin
                            bump_turns(2);
                            acc_travel += (nup == 0) ? span(t, s) : t - umax;
                            acc_travel += t + lmax;
                        end
                    end
                end else begin
                    if (nlow != 0) acc_travel += s - lmin;
                    if (nup != 0) begin
                        if (cur_policy == POL_SCAN) begin
                            bump_turns(1);
                            acc_travel += (nlow == 0) ? umax - s : lmin + umax;
                        end else begin
                            bump_turns(2);
                            acc_travel += ((nlow == 0) ? s : lmin) + t + (t - umin);
                        end
                    end
                end
            end
        endcase
        r.travel = acc_travel > 16777215 ? 24'hFFFFFF : acc_travel[23:0];
        r.turns = acc_turns[11:0];
        return r;
    endfunction

    // driver: one transfer at a time with a random gap before each
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn && !stim_done) begin
            if (s_tvalid && s_tready) begin
                if (list_q.size() < MAX_REQ) list_q.insert(list_q.size(), s_tdata);
                if (s_tlast) begin
                    cost_q.insert(cost_q.size(), schedule_cost());
                    list_q.delete();
                    n_lists++;
                end
                s_tvalid <= 1'b0;
                gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            end else if (!s_tvalid && pending_q.size() > 0) begin
                if (gap_left > 0) gap_left--;
                else if (!pending_q[0].hold || cost_q.size() == 0) begin
                    s_tdata <= pending_q[0].cyl;
                    s_tlast <= pending_q[0].last;
                    s_tvalid <= 1'b1;
                    pending_q.pop_front();
                end
            end
        end
    end

    // monitor: random backpressure and result check
    int stall_left = 0;
    always @(posedge aclk) begin
        cost_t exp_c;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (cost_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    exp_c = cost_q.pop_front();
                    n_checked++;
                    if (m_tdata[23:0] !== exp_c.travel || m_tdata[35:24] !== exp_c.turns) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("mismatch: travel exp %0d got %0d, turns exp %0d got %0d",
                                     exp_c.travel, m_tdata[23:0], exp_c.turns, m_tdata[35:24]);
                    end
                end
                stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
                m_tready <= stall_left == 0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= stall_left == 0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic add_req(input logic [15:0] c, input logic l, input logic h = 1'b0);
        req_t r;
        r.cyl = c;
        r.last = l;
        r.hold = h;
        pending_q.insert(pending_q.size(), r);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POLICY: cur_policy = val[1:0];
            REG_START:  cur_start = val;
            REG_PREV:   cur_prev = val;
            default:    cur_top = val;
        endcase
    endtask

    // run the queued items, then let the block go idle
    task automatic drain();
        while (pending_q.size() > 0 || s_tvalid || cost_q.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // a list of len requests, cylinders over the full range or within 0..6000, last one marked
    task automatic add_list(input int len, input bit spread);
        for (int i = 0; i < len; i++)
            add_req(spread ? 16'($urandom) : 16'($urandom_range(0, 6000)), i == len - 1);
    endtask

    initial begin
        int budget, len, top_choice;
        cur_policy = POL_FCFS; cur_start = 0; cur_prev = 0; cur_top = TOP_RESET;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes under reset settings, then each policy
        add_req(16'd0, 1'b0); add_req(16'hFFFF, 1'b0); add_req(16'd0, 1'b1);
        add_req(16'd4999, 1'b1);
        drain();
        for (int p = 0; p < 4; p++) begin
            set_reg(REG_POLICY, 16'(p));
            set_reg(REG_START, 16'd100);
            set_reg(REG_PREV, p[0] ? 16'd200 : 16'd50);
            set_reg(REG_TOP, p[1] ? 16'd1000 : 16'hFFFF);
            add_req(16'd150, 1'b0); add_req(16'd90, 1'b0); add_req(16'd110, 1'b0);
            add_req(16'd2000, 1'b0); add_req(16'd100, 1'b1);
            add_req(16'd40, 1'b1);             // lower half only
            add_req(16'd5000, 1'b1);           // dropped above the top for sweeps
            drain();
        end
        // start above top, tie for SSTF, then a list held until the block is empty
        set_reg(REG_POLICY, 16'(POL_SSTF));
        set_reg(REG_START, 16'hFFFF);
        set_reg(REG_PREV, 16'd0);
        set_reg(REG_TOP, 16'd1);
        add_req(16'd10, 1'b0); add_req(16'd10, 1'b0); add_req(16'hFFFF, 1'b1);
        add_req(16'd7, 1'b1, 1'b1);
        drain();

        // random phases
        budget = 48;
        while (budget > 0) begin
            set_reg(REG_POLICY, 16'($urandom_range(0, 3)));
            set_reg(REG_START, $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 6000)));
            set_reg(REG_PREV, $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom));
            top_choice = $urandom_range(0, 3);
            set_reg(REG_TOP, top_choice == 0 ? 16'd1 : top_choice == 1 ? 16'hFFFF
                                                : 16'($urandom_range(1, 7000)));
            for (int k = 0; k < 3 && budget > 0; k++) begin
                len = $urandom_range(1, 12);
                if ($urandom_range(0, 3) == 0) add_req(16'($urandom), 1'b1, 1'b1);
                add_list(len, $urandom_range(0, 1));
                budget -= len;
            end
            drain();
        end
        // one list overflowing the store, FCFS to keep it fast
        set_reg(REG_POLICY, 16'(POL_FCFS));
        add_list(MAX_REQ + 3, 1'b1);
        drain();

        $display("covered %0d request lists, %0d results checked across all policies",
                 n_lists, n_checked);
        if (n_bad == 0) begin
            $display("disk_schedule_cost_test passed");
        end else begin
            $display("%0d mismatches", n_bad);
            $display("disk_schedule_cost_test failed");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("disk_schedule_cost_test failed");
        $finish;
    end
endmodule
